@@ rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

    // Default number of ring store entries.
    localparam int DEPTH_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried in a request.
    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } deq_func_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // One request on the input channel.
    typedef struct packed {
        deq_func_t                  func;
        logic signed [DATA_W-1:0]   value;
    } deq_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic signed [DATA_W-1:0]   removed_value;
        deq_status_t                status;
        logic [COUNT_W-1:0]         element_count;
        logic                       is_empty;
    } deq_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        DEQ_IDLE,
        DEQ_EXEC,
        DEQ_RESP
    } deq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } deq_cmd_t;

endpackage

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue.
//
//  Channel   Ports                         Direction  Carries
//  request   s_valid, s_ready, s_payload   in         operation and value
//  result    m_valid, m_ready, m_payload   out        removed value, status, count
//
// Each request passes through three steps (accept, execute, present) and its
// result is held until m_ready; the registered read port of the ring
// store sets the execute step. One request is in flight at a time.
// Reset clears the front pointer and the element count; the ring store is
// not cleared. A stalled result holds m_payload steady and s_ready low.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_req_t s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_rsp_t m_payload
);

    deq_cmd_t cmd;

    // Sequencing of requests and results.
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Store, pointers and result formation.
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_payload),
        .m_rsp   (m_payload)
    );

endmodule

@@ rtl/deq_ctrl.sv @@
// Controller state machine that sequences one request at a time.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_cmd_t cmd
);

    deq_state_t state_reg;
    deq_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: take a request, execute it, then hold the result until taken.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DEQ_IDLE: begin
                if (s_valid) begin
                    state_next = DEQ_EXEC;
                end
            end
            DEQ_EXEC: begin
                state_next = DEQ_RESP;
            end
            DEQ_RESP: begin
                if (m_ready) begin
                    state_next = DEQ_IDLE;
                end
            end
            default: begin
                state_next = DEQ_IDLE;
            end
        endcase
    end

    // Outputs decoded from the current state.
    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            DEQ_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            DEQ_EXEC: begin
                cmd.exec = 1'b1;
            end
            DEQ_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/deq_dp.sv @@
// Datapath: request register, ring store, front pointer and element count.
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  deq_cmd_t cmd,
    input  deq_req_t s_req,
    output deq_rsp_t m_rsp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Ring store; entries are undefined until pushed.
    logic [DATA_W-1:0] mem [DEPTH];

    deq_req_t           req_reg;
    logic [PTR_W-1:0]   front_reg;
    logic [PTR_W-1:0]   front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    deq_status_t        status_reg;
    deq_status_t        status_next;
    logic               pop_ok_reg;
    logic               pop_ok_next;
    logic [DATA_W-1:0]  rd_data_reg;

    logic               is_full;
    logic               is_zero;
    logic [PTR_W-1:0]   front_dec;
    logic [PTR_W-1:0]   front_inc;
    logic [SUM_W-1:0]   back_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [PTR_W-1:0]   back_pos;
    logic [PTR_W-1:0]   last_pos;
    logic [PTR_W-1:0]   addr;
    logic               wr_en;
    logic               rd_en;

    // Capture the accepted request.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req;
        end
    end

    // Ring positions, each wrapped modulo the depth by one compare and a select or subtract.
    always_comb begin
        is_full   = (count_reg == CNT_W'(DEPTH));
        is_zero   = (count_reg == '0);
        front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
        front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
        back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
        last_sum  = back_sum - 1'b1;
        if (back_sum >= SUM_W'(DEPTH)) begin
            back_pos = PTR_W'(back_sum - SUM_W'(DEPTH));
        end else begin
            back_pos = PTR_W'(back_sum);
        end
        if (last_sum >= SUM_W'(DEPTH)) begin
            last_pos = PTR_W'(last_sum - SUM_W'(DEPTH));
        end else begin
            last_pos = PTR_W'(last_sum);
        end
    end

    // Decode the operation into store access, pointer update and status.
    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        addr        = front_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (req_reg.func)
            FN_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    front_next = front_dec;
                    addr       = front_dec;
                    wr_en      = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    addr       = back_pos;
                    wr_en      = cmd.exec;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (is_zero) begin
                    status_next = ST_EMPTY;
                end else begin
                    addr        = front_reg;
                    rd_en       = cmd.exec;
                    pop_ok_next = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (is_zero) begin
                    status_next = ST_EMPTY;
                end else begin
                    addr        = last_pos;
                    rd_en       = cmd.exec;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // Ring store with one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= req_reg.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    // Pointer and count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Result status held for the response.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // Result fields.
    always_comb begin
        m_rsp.removed_value = pop_ok_reg ? rd_data_reg : '0;
        m_rsp.status        = status_reg;
        m_rsp.element_count = COUNT_W'(count_reg);
        m_rsp.is_empty      = (count_reg == '0);
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam int HEAD_W       = $clog2(SLOTS);
    localparam int RANDOM_REQS  = 500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // One line of the directed stimulus table.
    typedef struct {
        deq_func_t                func;
        logic signed [DATA_W-1:0] value;
        int                       reps;
        bit                       typed;
        deq_rsp_t                 want;
    } step_row_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    deq_req_t s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    deq_rsp_t m_payload;

    // Shadow copy of the queue contents used for prediction.
    logic signed [DATA_W-1:0] shadow_slots [SLOTS];
    logic [HEAD_W-1:0]        shadow_head;
    logic [COUNT_W-1:0]       shadow_fill;

    deq_rsp_t awaited_rsp_q [$];
    int       fault_count   = 0;
    int       issued_count  = 0;
    int       results_seen  = 0;
    int       op_tally [4]  = '{0, 0, 0, 0};
    int       full_refusals = 0;
    int       empty_pops    = 0;
    int       burst_left    = 0;

    double_ended_queue #(
        .DEPTH(SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Builds an expected result for the directed table.
    function automatic deq_rsp_t rsp_of(input logic signed [DATA_W-1:0] removed,
                                        input deq_status_t status,
                                        input int count, input logic empty);
        deq_rsp_t rsp;
        rsp.removed_value = removed;
        rsp.status        = status;
        rsp.element_count = COUNT_W'(count);
        rsp.is_empty      = empty;
        return rsp;
    endfunction

    function automatic step_row_t row_of(input deq_func_t func,
                                         input logic signed [DATA_W-1:0] value,
                                         input int reps, input bit typed,
                                         input deq_rsp_t want);
        step_row_t r;
        r.func  = func;
        r.value = value;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Applies one request to the shadow queue and returns the result it should give.
    function automatic deq_rsp_t apply_deque_op(input deq_req_t req);
        deq_rsp_t          rsp;
        logic [HEAD_W-1:0] slot;
        rsp        = '0;
        rsp.status = ST_OK;
        case (req.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (shadow_fill == COUNT_W'(SLOTS)) begin
                    rsp.status = ST_FULL;
                    full_refusals++;
                end else begin
                    if (req.func == FN_PUSH_FRONT) begin
                        shadow_head = shadow_head - 1'b1;
                        slot        = shadow_head;
                    end else begin
                        slot = HEAD_W'(shadow_head + shadow_fill);
                    end
                    shadow_slots[slot] = req.value;
                    shadow_fill        = shadow_fill + 1'b1;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (shadow_fill == '0) begin
                    rsp.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    if (req.func == FN_POP_FRONT) begin
                        rsp.removed_value = shadow_slots[shadow_head];
                        shadow_head       = shadow_head + 1'b1;
                    end else begin
                        slot              = HEAD_W'(shadow_head + shadow_fill - 1'b1);
                        rsp.removed_value = shadow_slots[slot];
                    end
                    shadow_fill = shadow_fill - 1'b1;
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
        rsp.element_count = shadow_fill;
        rsp.is_empty      = (shadow_fill == '0);
        return rsp;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Presents one request, waits for it to be taken and records its expected result.
    task automatic issue_op(input deq_req_t req, input bit typed, input deq_rsp_t want);
        deq_rsp_t predicted;
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_deque_op(req);
        awaited_rsp_q.push_back(typed ? want : predicted);
        issued_count++;
        op_tally[req.func]++;
    endtask

    // Sender pacing: bursts of back-to-back requests separated by random gaps.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(0, 23);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Receiver back-pressure: a style is held for a segment, then another is picked.
    int unsigned rx_cycle = 0;
    int unsigned rx_left  = 0;
    int unsigned rx_style = 0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(16, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= rx_cycle[0];
            2: m_ready <= $urandom_range(0, 1);
            default: m_ready <= (rx_cycle % 12 == 0);
        endcase
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        deq_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_rsp_q.size() == 0) begin
                note_fault($sformatf("unexpected result removed=%h status=%0d count=%0d empty=%b",
                                     m_payload.removed_value, m_payload.status,
                                     m_payload.element_count, m_payload.is_empty));
            end else begin
                want = awaited_rsp_q.pop_front();
                if (m_payload.removed_value !== want.removed_value ||
                    m_payload.status        !== want.status ||
                    m_payload.element_count !== want.element_count ||
                    m_payload.is_empty      !== want.is_empty) begin
                    note_fault($sformatf(
                        "removed %h/%h status %0d/%0d count %0d/%0d empty %b/%b (exp/act)",
                        want.removed_value, m_payload.removed_value,
                        want.status, m_payload.status,
                        want.element_count, m_payload.element_count,
                        want.is_empty, m_payload.is_empty));
                end
            end
        end
    end

    // Watchdog: ends the run if no request or result moves for too long.
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", awaited_rsp_q.size());
            $display("double_ended_queue verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, shaped random traffic, drain.
    initial begin
        step_row_t   directed_rows [10];
        deq_req_t    req;
        int unsigned seq_left;
        int unsigned push_pct;
        bit          is_push;

        shadow_head = '0;
        shadow_fill = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty pops, both extremes with a wrap of the front pointer, fill to
        // the limit, refused pushes on a full queue, then a pop from each end.
        directed_rows = '{
            row_of(FN_POP_FRONT,  MOST_POS, 1, 1'b1, rsp_of(0, ST_EMPTY, 0, 1'b1)),
            row_of(FN_POP_BACK,   MOST_NEG, 1, 1'b1, rsp_of(0, ST_EMPTY, 0, 1'b1)),
            row_of(FN_PUSH_FRONT, MOST_NEG, 1, 1'b1, rsp_of(0, ST_OK, 1, 1'b0)),
            row_of(FN_PUSH_BACK,  MOST_POS, 1, 1'b1, rsp_of(0, ST_OK, 2, 1'b0)),
            row_of(FN_POP_FRONT,  '0,       1, 1'b1, rsp_of(MOST_NEG, ST_OK, 1, 1'b0)),
            row_of(FN_POP_BACK,   '1,       1, 1'b1, rsp_of(MOST_POS, ST_OK, 0, 1'b1)),
            row_of(FN_PUSH_BACK,  32'sd1,   8, 1'b0, '0),
            row_of(FN_PUSH_FRONT, -32'sd16, 8, 1'b0, '0),
            row_of(FN_PUSH_FRONT, MOST_POS, 1, 1'b1, rsp_of(0, ST_FULL, SLOTS, 1'b0)),
            row_of(FN_PUSH_BACK,  MOST_NEG, 1, 1'b1, rsp_of(0, ST_FULL, SLOTS, 1'b0))
        };
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                req.func  = directed_rows[r].func;
                req.value = directed_rows[r].value + k;
                issue_op(req, directed_rows[r].typed, directed_rows[r].want);
                pace_sender();
            end
        end
        req.func  = FN_POP_FRONT;
        req.value = '0;
        issue_op(req, 1'b0, '0);
        pace_sender();
        req.func = FN_POP_BACK;
        issue_op(req, 1'b0, '0);
        pace_sender();

        // Random traffic in runs that lean towards filling, draining or neither,
        // so the queue keeps reaching both its full and empty limits.
        seq_left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (seq_left == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                seq_left = $urandom_range(4, 40);
            end
            seq_left--;
            is_push = ($urandom_range(1, 100) <= push_pct);
            if (is_push) begin
                req.func = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            end else begin
                req.func = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            end
            case ($urandom_range(0, 9))
                0: req.value = MOST_NEG;
                1: req.value = MOST_POS;
                2: req.value = '0;
                3: req.value = '1;
                default: req.value = $urandom;
            endcase
            issue_op(req, 1'b0, '0);
            pace_sender();
        end
        if (s_valid) begin
            s_valid <= 1'b0;
        end

        // Wait for every outstanding result, then keep waiting so any stray result is seen.
        while (awaited_rsp_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d requests: push front %0d, push back %0d, pop front %0d, pop back %0d",
                 issued_count, op_tally[FN_PUSH_FRONT], op_tally[FN_PUSH_BACK],
                 op_tally[FN_POP_FRONT], op_tally[FN_POP_BACK]);
        $display("Checked %0d results, %0d refused pushes, %0d empty pops, %0d mismatches",
                 results_seen, full_refusals, empty_pops, fault_count);
        if (fault_count == 0) begin
            $display("double_ended_queue verification clean");
        end else begin
            $display("double_ended_queue verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
tb/sv/tb.sv
